FILE: rtl/prd_pkg.sv
// Package for the PCX run-length pixel decoder.
// Holds field widths, register indexes, controller states and the command/status structs.
// No dependencies.
package prd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 6;
  localparam int unsigned ColW      = 11;
  localparam int unsigned RowW      = 11;
  localparam int unsigned LimW      = 10;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned PixAddrW  = 20;
  localparam int unsigned RowSumW   = 12;
  localparam int unsigned RowProdW  = RowSumW + SizeW;
  localparam int unsigned AddrFullW = RowProdW + 1;

  localparam logic [ByteW-1:0] RunMark = 8'hC0;
  localparam logic [ByteW-1:0] RunMask = 8'h3F;

  localparam logic [CfgIdxW-1:0] CfgImageLastCol = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageLastRow = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLineStride   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFrameRows    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBaseRow      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_EMIT
  } prd_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take_data;   // capture a pixel byte and load the run count
    logic take_count;  // capture a run count byte
    logic mult;        // form the row base address
    logic emit;        // load one pixel into the output register
    logic update;      // apply the column wrap and the end test
  } prd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic finished;
    logic awaiting;
    logic is_run_mark;
    logic count_zero;
    logic count_one;
    logic out_free;
  } prd_status_t;

endpackage

FILE: rtl/prd_ctrl.sv
// Controller state machine of the PCX run-length pixel decoder.
// Depends on prd_pkg for the state type and the command/status structs.
module prd_ctrl import prd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  prd_status_t status_i,
  output prd_cmd_t    cmd_o
);

  prd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !status_i.finished) begin
          if (status_i.awaiting || !status_i.is_run_mark) begin
            state_d = ST_MULT;
          end
        end
      end
      ST_MULT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.count_zero) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free && status_i.count_one) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !status_i.finished) begin
          if (status_i.awaiting || !status_i.is_run_mark) begin
            cmd_o.take_data = 1'b1;
          end else begin
            cmd_o.take_count = 1'b1;
          end
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
      end
      ST_EMIT: begin
        if (status_i.count_zero) begin
          cmd_o.update = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.update = status_i.count_one;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Emission only happens in its own state, after the row base is formed.
  a_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> $past(state_q) == ST_MULT || $past(state_q) == ST_EMIT)
    else $error("pixel emitted without a row base computed");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULT |=> state_q == ST_EMIT)
    else $error("row base step not followed by emission");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && status_i.finished) |=> state_q == ST_IDLE)
    else $error("decoder left idle after finishing");

endmodule

FILE: rtl/prd_datapath.sv
// Datapath of the PCX run-length pixel decoder: registers, position state,
// address arithmetic and the output register. Depends on prd_pkg.
module prd_datapath import prd_pkg::*; #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [ByteW-1:0]    code_byte_i,
  input  prd_cmd_t            cmd_i,
  output prd_status_t         status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixAddrW-1:0] pixel_address_o,
  output logic [ByteW-1:0]    pixel_color_o,
  output logic                last_of_run_o,
  output logic                image_done_o
);

  localparam logic [AddrFullW-1:0] AddrMask = (ADDR_BITS >= AddrFullW) ? '1 :
      AddrFullW'((64'd1 << ADDR_BITS) - 64'd1);

  // Configuration registers.
  logic [LimW-1:0]  last_col_q, last_row_q, base_row_q;
  logic [SizeW-1:0] stride_q, frame_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q   <= 10'd319;
      last_row_q   <= 10'd199;
      stride_q     <= 11'd352;
      frame_rows_q <= 11'd744;
      base_row_q   <= 10'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgImageLastCol: last_col_q   <= cfg_wdata_i[LimW-1:0];
        CfgImageLastRow: last_row_q   <= cfg_wdata_i[LimW-1:0];
        CfgLineStride:   stride_q     <= cfg_wdata_i;
        CfgFrameRows:    frame_rows_q <= cfg_wdata_i;
        CfgBaseRow:      base_row_q   <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Decoder state.
  logic [CountW-1:0]   pending_q, count_q;
  logic                awaiting_q, finished_q;
  logic [ColW-1:0]     column_q;
  logic [RowW-1:0]     row_q;
  logic [ByteW-1:0]    color_q;
  logic [RowProdW-1:0] row_prod_q;
  logic                out_valid_q, last_q, done_q;
  logic [PixAddrW-1:0] addr_q;
  logic [ByteW-1:0]    out_color_q;

  logic [RowSumW-1:0]   row_sum;
  logic [AddrFullW-1:0] addr_full;
  logic [SizeW-1:0]     stride_top, rows_top, max_col, max_row;
  logic [ColW-1:0]      col_cand;
  logic [RowW-1:0]      row_inc;
  logic                 wrap, done_cand, out_free;

  assign row_sum   = RowSumW'(base_row_q) + RowSumW'(row_q);
  assign addr_full = (AddrFullW'(row_prod_q) + AddrFullW'(column_q)) & AddrMask;

  // Effective last column and row, clamped to the frame size minus one.
  assign stride_top = (stride_q == '0) ? '0 : stride_q - 11'd1;
  assign rows_top   = (frame_rows_q == '0) ? '0 : frame_rows_q - 11'd1;
  assign max_col    = (SizeW'(last_col_q) > stride_top) ? stride_top : SizeW'(last_col_q);
  assign max_row    = (SizeW'(last_row_q) > rows_top) ? rows_top : SizeW'(last_row_q);

  assign col_cand  = cmd_i.emit ? column_q + 11'd1 : column_q;
  assign wrap      = col_cand > max_col;
  assign row_inc   = row_q + 11'd1;
  assign done_cand = (wrap ? row_inc : row_q) > max_row;
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      count_q     <= '0;
      awaiting_q  <= 1'b0;
      finished_q  <= 1'b0;
      column_q    <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_count) begin
        pending_q  <= code_byte_i[CountW-1:0] & RunMask[CountW-1:0];
        awaiting_q <= 1'b1;
      end
      if (cmd_i.take_data) begin
        count_q    <= awaiting_q ? pending_q : CountW'(1);
        pending_q  <= '0;
        awaiting_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        count_q <= count_q - 6'd1;
      end
      if (cmd_i.update) begin
        if (wrap) begin
          column_q <= '0;
          row_q    <= row_inc;
        end else begin
          column_q <= col_cand;
        end
        finished_q <= done_cand;
      end else if (cmd_i.emit) begin
        column_q <= col_cand;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers. The run color is copied into the output register so that
  // a new byte taken while a pixel still waits cannot change that pixel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data) begin
      color_q <= code_byte_i;
    end
    if (cmd_i.mult) begin
      row_prod_q <= RowProdW'(row_sum) * RowProdW'(stride_q);
    end
    if (cmd_i.emit) begin
      addr_q      <= addr_full[PixAddrW-1:0];
      out_color_q <= color_q;
      last_q      <= cmd_i.update;
      done_q      <= cmd_i.update && done_cand;
    end
  end

  assign status_o.finished    = finished_q;
  assign status_o.awaiting    = awaiting_q;
  assign status_o.is_run_mark = (code_byte_i & RunMark) == RunMark;
  assign status_o.count_zero  = count_q == '0;
  assign status_o.count_one   = count_q == CountW'(1);
  assign status_o.out_free    = out_free;

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_of_run_o   = last_q;
  assign image_done_o    = done_q;

  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("finished flag cleared without reset");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("pixel loaded over an unread result");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> last_q)
    else $error("image done flagged on a pixel that does not end its byte");

  a_count_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_count |=> awaiting_q)
    else $error("run count byte did not arm the color byte");

endmodule

FILE: rtl/pcx_rle_pixel_decoder.sv
// PCX run-length pixel decoder: top level joining the controller and the datapath.
// Depends on prd_pkg, prd_ctrl and prd_datapath.
//
// Usage. Encoded image bytes enter one per request on the input channel
// (in_valid_i / in_ready_o, code_byte_i). Each pixel leaves as one request on
// the output channel carrying its frame-buffer address, its palette index and
// two flags: last_of_run_o marks the final pixel caused by one input byte, and
// image_done_o marks that pixel when it also completes the last image row.
// The user writes the five configuration registers through cfg_we_i, cfg_index_i
// and cfg_wdata_i only while the decoder is idle; the block does not enforce it.
// Timing. A run count byte is taken and yields nothing. Once a literal byte, or
// the color byte of a run of n pixels, is taken, the input stalls while the row
// base address is formed in the multiplier and then while its pixels leave one
// per cycle from the single output register, as long as the receiver does not
// stall. The color byte of an empty run goes through the same multiply step and
// yields nothing, and the decoder then returns to idle.
// Reset clears the position, the pending run and the finished flag, and loads
// the register defaults (320 by 200 image, stride 352, 744 frame rows).
// When the receiver stalls, the pixel waits in the output register and the
// decoder holds until it is taken. Once the last row is done, bytes are
// accepted and dropped until the next reset.
module pcx_rle_pixel_decoder import prd_pkg::*; #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    code_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixAddrW-1:0] pixel_address_o,
  output logic [ByteW-1:0]    pixel_color_o,
  output logic                last_of_run_o,
  output logic                image_done_o
);

  prd_cmd_t    cmd;
  prd_status_t status;

  // The controller sequences each literal or color byte: accept, row base multiply, pixel emission.
  prd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration, position and output registers and produces the pixel requests.
  prd_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .code_byte_i     (code_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .last_of_run_o   (last_of_run_o),
    .image_done_o    (image_done_o)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for the PCX run-length pixel decoder (top level pcx_rle_pixel_decoder).
// Drives encoded bytes and register settings, and checks every pixel write against a
// built-in model of the decoder or a typed table row. Depends on prd_pkg and the decoder RTL.
module tb;
  import prd_pkg::*;

  localparam int unsigned AddrBits      = 20;
  // A run of 63 pixels plus the byte and multiply cycles, with margin.
  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned ItemsPerPhase = 72;

  // One frame-buffer write as the decoder presents it on the output channel.
  typedef struct packed {
    logic [PixAddrW-1:0] addr;
    logic [ByteW-1:0]    color;
    logic                last_of_run;
    logic                image_done;
  } pixel_t;

  // All five registers in index order.
  typedef logic [4:0][CfgDataW-1:0] reg_set_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_SETTINGS
  } row_kind_e;

  // One row of the directed stimulus table. A typed row carries the single pixel
  // that its byte must produce; all other byte rows are checked by the model.
  typedef struct {
    row_kind_e        kind;
    logic [ByteW-1:0] code;
    bit               typed;
    pixel_t           pix;
    reg_set_t         regs;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    code_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PixAddrW-1:0] pixel_address_o;
  logic [ByteW-1:0]    pixel_color_o;
  logic                last_of_run_o;
  logic                image_done_o;

  pcx_rle_pixel_decoder #(
    .ADDR_BITS(AddrBits)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_byte_i    (code_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_address_o(pixel_address_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_run_o  (last_of_run_o),
    .image_done_o   (image_done_o)
  );

  // Shadow copy of the registers, loaded with the reset defaults of the decoder.
  logic [LimW-1:0]  lim_col     = 10'd319;
  logic [LimW-1:0]  lim_row     = 10'd199;
  logic [SizeW-1:0] stride_px   = 11'd352;
  logic [SizeW-1:0] frame_lines = 11'd744;
  logic [LimW-1:0]  start_row   = 10'd0;

  // Decoding position of the model. All of it starts cleared, as the decoder's does after reset.
  logic [CountW-1:0] run_left    = '0;
  bit                color_next  = 1'b0;
  logic [ColW-1:0]   cur_col     = '0;
  logic [RowW-1:0]   cur_row     = '0;
  bit                decode_over = 1'b0;

  pixel_t      pending_writes[$];
  plan_row_t   plan[$];
  bit          typed_next = 1'b0;
  pixel_t      typed_pixel;
  int unsigned bytes_taken = 0;
  int unsigned mismatches  = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit. The slowest plausible run, with every run at 63 pixels and the
  // receiver stalling most cycles, stays well below this.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR at %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Last usable index of a dimension: the header limit, clamped to the frame size
  // minus one. A zero size clamps to index 0.
  function automatic logic [SizeW-1:0] last_index(input logic [SizeW-1:0] lim,
                                                  input logic [SizeW-1:0] size);
    logic [SizeW-1:0] top;
    top = (size == '0) ? '0 : size - 1'b1;
    return (lim > top) ? top : lim;
  endfunction

  // Works out the pixel writes that one accepted byte causes and queues them.
  function automatic void decode_byte(input logic [ByteW-1:0] code);
    int unsigned     run_len;
    logic [ColW-1:0] col0;
    logic [RowW-1:0] row0;
    longint unsigned addr;
    pixel_t          px;
    if (decode_over) return;
    if (color_next) begin
      // The byte after a count is always a color, whatever its top bits say.
      run_len    = 32'(run_left);
      color_next = 1'b0;
      run_left   = '0;
    end else if ((code & RunMark) == RunMark) begin
      run_left   = code[CountW-1:0];
      color_next = 1'b1;
      return;
    end else begin
      run_len = 1;
    end
    col0 = cur_col;
    row0 = cur_row;
    // A run may run past the last column; the wrap comes only after the whole run.
    cur_col = ColW'(cur_col + run_len);
    if (cur_col > last_index(SizeW'(lim_col), stride_px)) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
    end
    if (cur_row > last_index(SizeW'(lim_row), frame_lines)) decode_over = 1'b1;
    if (typed_next) begin
      typed_next = 1'b0;
      pending_writes.push_back(typed_pixel);
      return;
    end
    for (int k = 0; k < run_len; k++) begin
      addr = (64'(start_row) + 64'(row0)) * 64'(stride_px) + 64'(ColW'(col0 + k));
      px.addr        = PixAddrW'(addr & ((64'd1 << AddrBits) - 1));
      px.color       = code;
      px.last_of_run = (k == run_len - 1);
      px.image_done  = (k == run_len - 1) && decode_over;
      pending_writes.push_back(px);
    end
  endfunction

  task automatic check_pixel();
    pixel_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch("unexpected pixel at address", pixel_address_o, 0);
      return;
    end
    want = pending_writes.pop_front();
    if (pixel_address_o !== want.addr)
      report_mismatch("pixel_address", pixel_address_o, want.addr);
    if (pixel_color_o !== want.color)
      report_mismatch("pixel_color", pixel_color_o, want.color);
    if (last_of_run_o !== want.last_of_run)
      report_mismatch("last_of_run", last_of_run_o, want.last_of_run);
    if (image_done_o !== want.image_done)
      report_mismatch("image_done", image_done_o, want.image_done);
  endtask

  // Both channels are sampled here, at the rising edge, before the decoder's
  // registers take their new values.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      bytes_taken++;
      decode_byte(code_byte_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) check_pixel();
  end

  // Receiver. It stalls at random at the current rate, and holds off for a long
  // stretch whenever the stimulus asks for one, counting the cycles itself.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic reg_set_t make_regs(input int unsigned last_col, input int unsigned last_row,
                                         input int unsigned stride, input int unsigned rows,
                                         input int unsigned base);
    reg_set_t regs;
    regs[CfgImageLastCol] = CfgDataW'(last_col);
    regs[CfgImageLastRow] = CfgDataW'(last_row);
    regs[CfgLineStride]   = CfgDataW'(stride);
    regs[CfgFrameRows]    = CfgDataW'(rows);
    regs[CfgBaseRow]      = CfgDataW'(base);
    return regs;
  endfunction

  function automatic void add_byte(input logic [ByteW-1:0] code);
    plan_row_t r;
    r.kind  = ROW_BYTE;
    r.code  = code;
    r.typed = 1'b0;
    plan.push_back(r);
  endfunction

  // Typed rows are single pixels, so each is the last of its byte and none ends
  // the image.
  function automatic void add_pixel(input logic [ByteW-1:0] code,
                                    input logic [PixAddrW-1:0] addr,
                                    input logic [ByteW-1:0] color);
    plan_row_t r;
    r.kind  = ROW_BYTE;
    r.code  = code;
    r.typed = 1'b1;
    r.pix   = '{addr: addr, color: color, last_of_run: 1'b1, image_done: 1'b0};
    plan.push_back(r);
  endfunction

  function automatic void add_settings(input reg_set_t regs);
    plan_row_t r;
    r.kind  = ROW_SETTINGS;
    r.typed = 1'b0;
    r.regs  = regs;
    plan.push_back(r);
  endfunction

  // Writes all five registers on consecutive cycles. Called at a falling edge
  // while the decoder is idle, so the shadow copy may change at once.
  task automatic load_settings(input reg_set_t regs);
    for (int i = CfgImageLastCol; i <= CfgBaseRow; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_wdata_i <= regs[i];
      case (CfgIdxW'(i))
        CfgImageLastCol: lim_col     = regs[i][LimW-1:0];
        CfgImageLastRow: lim_row     = regs[i][LimW-1:0];
        CfgLineStride:   stride_px   = regs[i][SizeW-1:0];
        CfgFrameRows:    frame_lines = regs[i][SizeW-1:0];
        CfgBaseRow:      start_row   = regs[i][LimW-1:0];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offers one byte as a request and returns at the falling edge after it was
  // taken, with valid still high so that a following byte can go out at once.
  task automatic send_byte(input logic [ByteW-1:0] code);
    int unsigned seen;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    seen = bytes_taken;
    in_valid_i  <= 1'b1;
    code_byte_i <= code;
    do @(negedge clk_i); while (bytes_taken == seen);
  endtask

  // Stops offering and waits until every queued pixel has come out, then lets the
  // decoder finish any byte that produces nothing, such as an empty run.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    int unsigned last_col;
    int unsigned stride;
    int unsigned base;
    bit          paused;
    bit          held;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    code_byte_i = '0;

    // Directed table. The first bytes run on the reset defaults, so their
    // addresses are simply the column.
    add_pixel(8'h00, 20'd0, 8'h00);
    add_pixel(8'hBF, 20'd1, 8'hBF);          // top bits 10: still a literal
    // Zero last row and a single frame line: harmless while no row wraps.
    add_settings(make_regs(319, 0, 352, 1, 0));
    add_byte(8'hC1);                          // count of one
    add_pixel(8'hFF, 20'd2, 8'hFF);           // color with the run mark set
    add_byte(8'hC0);                          // empty run: its color gives nothing
    add_byte(8'h7F);
    add_byte(8'hFF);                          // longest run
    add_byte(8'hC0);
    add_byte(8'h40);
    // One-column image at the widest stride from the bottom frame row, changed in
    // the middle of a line: the addresses wrap past the top of the buffer.
    add_settings(make_regs(0, 1023, 1024, 1024, 1023));
    add_byte(8'h12);
    add_byte(8'h34);
    add_byte(8'hC5);                          // run that goes past the last column
    add_byte(8'hAA);
    // Zero stride clamps the last column to 0 and makes the address the column.
    add_settings(make_regs(1023, 1023, 0, 1024, 1023));
    add_pixel(8'h01, 20'd0, 8'h01);
    add_byte(8'hC2);
    add_byte(8'h02);
    add_settings(make_regs(319, 1023, 352, 1024, 0));
    add_byte(8'h80);
    add_byte(8'h55);

    tx_idle_pct = 11;
    rx_idle_pct = 84;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTINGS) begin
        wait_idle();
        load_settings(plan[i].regs);
      end else begin
        typed_next  = plan[i].typed;
        typed_pixel = plan[i].pix;
        send_byte(plan[i].code);
      end
    end

    // Random phases. Each keeps the last row far beyond any row these items can
    // reach, so decoding goes on until the final step below.
    paused = 1'b0;
    held   = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 84;
          last_col    = 1023;                 // clamped to 0 by the unit stride
          stride      = 1;
          base        = $urandom_range(1023);
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 11;
          last_col    = $urandom_range(1023);
          stride      = $urandom_range(1024, 1);
          base        = $urandom_range(1023);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          last_col    = $urandom_range(40);
          stride      = 1024;
          base        = 1023;
        end
      endcase
      wait_idle();
      load_settings(make_regs(last_col, $urandom_range(1023, 512), stride,
                              $urandom_range(1024, 768), base));
      sent = 0;
      while (sent < ItemsPerPhase) begin
        // Once, the sender waits for every pixel before going on.
        if (phase == 0 && sent >= 40 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        // Once, the receiver holds off long enough to fill the decoder while the
        // sender keeps offering.
        if (phase == 2 && sent >= 20 && !held) begin
          hold_left = LongHold;
          held      = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
          send_byte(ByteW'($urandom_range(8'hBF)));
          sent++;
        end else if (pick < 90) begin
          pick    = $urandom_range(99);
          run_len = (pick < 10) ? 0 : (pick < 80) ? $urandom_range(8, 1)
                                                  : $urandom_range(63, 9);
          send_byte(RunMark | ByteW'(run_len));
          send_byte(ByteW'($urandom_range(255)));
          sent += 2;
        end else begin
          // Loose byte: a stray count here turns the next byte into a color.
          send_byte(ByteW'($urandom_range(255)));
          sent++;
        end
      end
    end

    // Close a run left open by a stray count, then end the image: with zero frame
    // rows the last row clamps to 0, so the next literal finishes decoding.
    wait_idle();
    if (color_next) begin
      send_byte(8'h00);
      wait_idle();
    end
    load_settings(make_regs(319, 1023, 352, 0, 0));
    send_byte(8'h5A);
    // Everything after the end is dropped without a pixel.
    send_byte(8'hC5);
    send_byte(8'h77);
    send_byte(8'h21);
    wait_idle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/prd_pkg.sv
rtl/prd_ctrl.sv
rtl/prd_datapath.sv
rtl/pcx_rle_pixel_decoder.sv
bench/tb.sv
